### src/tct_pkg.sv
// ----------------------------------------------------------------------------
// tct_pkg
// Shared types and constants for the 16-bit target compare timer.
// ----------------------------------------------------------------------------
`default_nettype none

package tct_pkg;

    localparam int unsigned DATA_W = 16;
    localparam int unsigned FUNC_W = 2;
    localparam int unsigned OFF_W  = 4;
    localparam int unsigned SRC_W  = 2;
    localparam int unsigned PRESC_W = 4;

    // clock source id that advances the counter
    localparam logic [SRC_W-1:0] SYSTEM_SOURCE = 2'd0;

    // item function codes
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;

    // register offsets
    localparam logic [OFF_W-1:0] OFF_COUNT  = 4'd0;
    localparam logic [OFF_W-1:0] OFF_MODE   = 4'd4;
    localparam logic [OFF_W-1:0] OFF_TARGET = 4'd8;

    // mode word bit positions
    localparam int unsigned MB_RESET  = 3;
    localparam int unsigned MB_IRQTGT = 4;
    localparam int unsigned MB_PULSE  = 7;
    localparam int unsigned MB_PRESC  = 9;
    localparam int unsigned MB_IRQ    = 10;
    localparam int unsigned MB_TARGET = 11;
    localparam int unsigned MB_WRAP   = 12;

    localparam int unsigned MODE_CHK_W = 10;
    localparam logic [MODE_CHK_W-1:0] MODE_OK_A = 10'h000;
    localparam logic [MODE_CHK_W-1:0] MODE_OK_B = 10'h248;
    localparam logic [MODE_CHK_W-1:0] MODE_OK_C = 10'h258;

    localparam logic [DATA_W-1:0]  COUNT_MAX   = 16'hFFFF;
    localparam logic [DATA_W-1:0]  COUNT_ARM   = 16'd32;
    localparam logic [PRESC_W-1:0] PRESC_LAST  = 4'd8;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [OFF_W-1:0]  reg_offset;
        logic [DATA_W-1:0] write_data;
        logic [SRC_W-1:0]  tick_source;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_pulse;
        logic              unsupported_mode;
    } t_result;

endpackage

`default_nettype wire

### src/tct_cmd_if.sv
// ----------------------------------------------------------------------------
// tct_cmd_if
// Command channel: tick, register read or register write items.
// ----------------------------------------------------------------------------
`default_nettype none

interface tct_cmd_if import tct_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [OFF_W-1:0]  reg_offset;
    logic [DATA_W-1:0] write_data;
    logic [SRC_W-1:0]  tick_source;

    modport source (output valid, func, reg_offset, write_data, tick_source,
                    input ready);
    modport sink   (input valid, func, reg_offset, write_data, tick_source,
                    output ready);
endinterface

`default_nettype wire

### src/tct_rsp_if.sv
// ----------------------------------------------------------------------------
// tct_rsp_if
// Response channel: one result item for every command item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tct_rsp_if import tct_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              irq_pulse;
    logic              unsupported_mode;

    modport source (output valid, read_data, irq_pulse, unsupported_mode,
                    input ready);
    modport sink   (input valid, read_data, irq_pulse, unsupported_mode,
                    output ready);
endinterface

`default_nettype wire

### src/tct_core.sv
// ----------------------------------------------------------------------------
// tct_core
// Timer registers and the per-item update: count, mode, target, prescaler.
// ----------------------------------------------------------------------------
`default_nettype none

module tct_core import tct_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_en,
    input  wire t_item   i_item,
    output t_result      o_res
);

    logic [DATA_W-1:0]  r_count, n_count;
    logic [DATA_W-1:0]  r_target, n_target;
    logic [DATA_W-1:0]  r_mode, n_mode;
    logic [PRESC_W-1:0] r_presc, n_presc;
    logic [MODE_CHK_W-1:0] mode_low;

    assign mode_low = i_item.write_data[MODE_CHK_W-1:0];

    always_comb begin
        n_count  = r_count;
        n_target = r_target;
        n_mode   = r_mode;
        n_presc  = r_presc;
        o_res    = '0;
        case (i_item.func)
            FUNC_TICK: begin
                if (i_item.tick_source == SYSTEM_SOURCE) begin
                    if (r_mode[MB_RESET] && (r_count == r_target)) begin
                        n_count = '0;
                        n_mode[MB_TARGET] = 1'b1;
                        if (r_mode[MB_IRQTGT]) begin
                            o_res.irq_pulse = r_mode[MB_IRQ];
                            n_mode[MB_IRQ]  = 1'b0;
                        end
                    end else if (!r_mode[MB_RESET] && (r_count == COUNT_MAX)) begin
                        n_count = '0;
                        n_mode[MB_WRAP] = 1'b1;
                    end else begin
                        if (!r_mode[MB_PULSE] && !r_mode[MB_IRQ] && (r_count == COUNT_ARM))
                            n_mode[MB_IRQ] = 1'b1;
                        if (r_mode[MB_PRESC]) begin
                            if (r_presc >= PRESC_LAST) begin
                                n_presc = '0;
                                n_count = r_count + DATA_W'(1);
                            end else begin
                                n_presc = r_presc + PRESC_W'(1);
                            end
                        end else begin
                            n_count = r_count + DATA_W'(1);
                        end
                    end
                end
            end
            FUNC_READ: begin
                case (i_item.reg_offset)
                    OFF_COUNT:  o_res.read_data = r_count;
                    OFF_MODE: begin
                        o_res.read_data   = r_mode;
                        n_mode[MB_TARGET] = 1'b0;
                        n_mode[MB_WRAP]   = 1'b0;
                    end
                    OFF_TARGET: o_res.read_data = r_target;
                    default:    o_res.read_data = '0;
                endcase
            end
            FUNC_WRITE: begin
                case (i_item.reg_offset)
                    OFF_COUNT:  n_count = i_item.write_data;
                    OFF_MODE: begin
                        n_mode = i_item.write_data;
                        o_res.unsupported_mode = (mode_low != MODE_OK_A) &&
                                                 (mode_low != MODE_OK_B) &&
                                                 (mode_low != MODE_OK_C);
                    end
                    OFF_TARGET: n_target = i_item.write_data;
                    default:    ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_target <= '0;
            r_mode   <= '0;
            r_presc  <= '0;
        end else if (i_en) begin
            r_count  <= n_count;
            r_target <= n_target;
            r_mode   <= n_mode;
            r_presc  <= n_presc;
        end
    end

    // prescaler never leaves 0..8
    a_presc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_presc <= PRESC_LAST)
        else $error("prescaler out of range");

    // a tick from a foreign source leaves all state alone
    a_foreign_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && (i_item.func == FUNC_TICK) && (i_item.tick_source != SYSTEM_SOURCE))
        |=> ($stable(r_count) && $stable(r_mode) && $stable(r_presc)))
        else $error("foreign tick changed state");

    // an interrupt consumes the armed bit
    a_irq_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_res.irq_pulse) |=> (!r_mode[MB_IRQ] && r_mode[MB_TARGET]))
        else $error("irq armed bit not cleared");

    // mode flag only on a mode write
    a_bad_mode_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.unsupported_mode |->
            ((i_item.func == FUNC_WRITE) && (i_item.reg_offset == OFF_MODE)))
        else $error("unsupported_mode outside a mode write");

endmodule

`default_nettype wire

### src/target_compare_timer_16bit.sv
// ----------------------------------------------------------------------------
// target_compare_timer_16bit
// 16-bit timer with target compare, wrap flag and divide-by-nine prescaler.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one item per handshake: a tick (func 0), a register read
//   (func 1) or a register write (func 2) at offset 0 count, 4 mode,
//   8 target. o_rsp returns exactly one result item per command item, in
//   order: read data, target interrupt pulse and unsupported-mode flag.
//   An accepted command is held in the input register; the timer update
//   and result then land in the output register together, which raises
//   o_rsp.valid. Throughput is one item per cycle while o_rsp does not
//   stall; the timer state loop (count/mode compare and increment) is
//   computed combinationally from the registered state, so back-to-back
//   ticks each advance the counter.
//   When o_rsp stalls, the output register holds its item and the input
//   register still takes one more item; i_cmd.ready drops only when both
//   are full.
//   Synchronous reset clears count, target, mode, prescaler and both
//   pipeline valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module target_compare_timer_16bit import tct_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tct_cmd_if.sink    i_cmd,
    tct_rsp_if.source  o_rsp
);

    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_result core_res;
    logic    out_free;
    logic    advance;
    logic    in_take;

    assign out_free = !r_out_valid || o_rsp.ready;
    assign advance  = r_in_valid && out_free;
    assign i_cmd.ready = !r_in_valid || out_free;
    assign in_take  = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.func        <= i_cmd.func;
            r_in.reg_offset  <= i_cmd.reg_offset;
            r_in.write_data  <= i_cmd.write_data;
            r_in.tick_source <= i_cmd.tick_source;
        end
    end

    tct_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_item  (r_in),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.read_data        = r_out.read_data;
    assign o_rsp.irq_pulse        = r_out.irq_pulse;
    assign o_rsp.unsupported_mode = r_out.unsupported_mode;

    // a stalled result keeps the input register from being overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_rsp.ready) |-> !i_cmd.ready)
        else $error("input register overrun");

    // an item that advances out of the input register reaches the output on the next edge
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed item lost");

    // results only follow accepted items
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_valid && (!r_out_valid || o_rsp.ready)) |=> !r_out_valid)
        else $error("result without item");

endmodule

`default_nettype wire
